// ===== sv/xp_pkg.sv =====
// xp_pkg: shared types, constants and microcode ROM for the XTEA random generator.
// No dependencies; imported by xp_core, xtea_prng, xtea_prng_chk and xtea_prng_tb.
package xp_pkg;

  localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;
  localparam logic [3:0][31:0] SEED_KEY = {
    32'hB172_E6B0, 32'h2A77_FB57, 32'h993F_DDD1, 32'h2DE9_716E
  };

  localparam int unsigned UPC_W = 5;

  localparam logic [UPC_W-1:0] ADDR_DRAW = 5'd0;
  localparam logic [UPC_W-1:0] ADDR_DONE = 5'd1;
  localparam logic [UPC_W-1:0] ADDR_SEED = 5'd2;
  localparam logic [UPC_W-1:0] ADDR_LAST = 5'd19;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_PEEK2 = 2'd1,
    OP_PEEK1 = 2'd2,
    OP_SEED  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_SET  = 2'd0,
    ACT_ENC  = 2'd1,
    ACT_DONE = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    SRC_W0 = 2'd0,
    SRC_W1 = 2'd1,
    SRC_A  = 2'd2,
    SRC_B  = 2'd3
  } src_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  typedef struct packed {
    act_e             act;
    logic             ld_key;
    logic             clr;
    logic             kx;
    src_e             src;
    logic             shr;
    logic [1:0]       kidx;
    logic [UPC_W-1:0] nxt;
  } uword_t;

  typedef struct packed {
    logic       enc;
    logic       step;
    logic       ld_key;
    logic       clr;
    logic       kx;
    src_e       src;
    logic       shr;
    logic [1:0] kidx;
  } core_ctl_t;

  function automatic logic [31:0] mix(input logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  function automatic uword_t uw_enc(input logic [UPC_W-1:0] nxt);
    uword_t w;
    w     = '0;
    w.act = ACT_ENC;
    w.nxt = nxt;
    return w;
  endfunction

  function automatic uword_t uw_kx(input logic [1:0] kidx, input src_e src,
                                   input logic shr, input logic clr,
                                   input logic [UPC_W-1:0] nxt);
    uword_t w;
    w      = '0;
    w.act  = ACT_SET;
    w.kx   = 1'b1;
    w.kidx = kidx;
    w.src  = src;
    w.shr  = shr;
    w.clr  = clr;
    w.nxt  = nxt;
    return w;
  endfunction

  // Program: draw at ADDR_DRAW, peeks at ADDR_DONE, seed at ADDR_SEED.
  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '0;
    unique case (addr)
      5'd0:  w = uw_enc(ADDR_DONE);
      5'd2:  begin
        w.act    = ACT_SET;
        w.ld_key = 1'b1;
        w.clr    = 1'b1;
        w.nxt    = 5'd3;
      end
      5'd3:  w = uw_enc(5'd4);
      5'd4:  w = uw_kx(2'd0, SRC_W1, 1'b0, 1'b0, 5'd5);
      5'd5:  w = uw_enc(5'd6);
      5'd6:  w = uw_kx(2'd1, SRC_A, 1'b0, 1'b0, 5'd7);
      5'd7:  w = uw_enc(5'd8);
      5'd8:  w = uw_kx(2'd2, SRC_A, 1'b1, 1'b0, 5'd9);
      5'd9:  w = uw_enc(5'd10);
      5'd10: w = uw_kx(2'd3, SRC_W1, 1'b1, 1'b0, 5'd11);
      5'd11: w = uw_enc(5'd12);
      5'd12: w = uw_kx(2'd0, SRC_B, 1'b0, 1'b0, 5'd13);
      5'd13: w = uw_enc(5'd14);
      5'd14: w = uw_kx(2'd1, SRC_W0, 1'b0, 1'b0, 5'd15);
      5'd15: w = uw_enc(5'd16);
      5'd16: w = uw_kx(2'd2, SRC_W0, 1'b1, 1'b0, 5'd17);
      5'd17: w = uw_enc(5'd18);
      5'd18: w = uw_kx(2'd3, SRC_B, 1'b1, 1'b1, 5'd19);
      5'd19: w = uw_enc(ADDR_DONE);
      default: begin
        w.act = ACT_DONE;
        w.nxt = ADDR_DRAW;
      end
    endcase
    return w;
  endfunction

  function automatic logic [UPC_W-1:0] entry(input op_e op);
    logic [UPC_W-1:0] a;
    a = ADDR_DONE;
    unique case (op)
      OP_DRAW:  a = ADDR_DRAW;
      OP_SEED:  a = ADDR_SEED;
      default:  a = ADDR_DONE;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/xp_core.sv =====
// xp_core: XTEA datapath with cipher words, key words and one half-round per cycle.
// Driven by the microcode sequencer in xtea_prng; uses xp_pkg.
module xp_core #(
  parameter int unsigned ROUND_CYCLES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xp_pkg::core_ctl_t ctl_i,
  input  logic [31:0]       seed_a_i,
  input  logic [31:0]       seed_b_i,
  output logic              last_o,
  output logic [31:0]       mix_o
);
  import xp_pkg::*;

  localparam int unsigned CntW = (ROUND_CYCLES > 1) ? $clog2(ROUND_CYCLES) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(ROUND_CYCLES - 1);

  logic [1:0][31:0] w_q, w_d;
  logic [3:0][31:0] key_q, key_d;
  logic [31:0]      sum_q, sum_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             phase_q, phase_d;
  logic [31:0]      src_val, kx_val;

  always_comb begin
    unique case (ctl_i.src)
      SRC_W0:  src_val = w_q[0];
      SRC_W1:  src_val = w_q[1];
      SRC_A:   src_val = seed_a_i;
      default: src_val = seed_b_i;
    endcase
    kx_val = ctl_i.shr ? (src_val >> 1) : (src_val << 1);
  end

  always_comb begin
    w_d     = w_q;
    key_d   = key_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    if (ctl_i.enc) begin
      if (!phase_q) begin
        w_d[0]  = w_q[0] + (mix(w_q[1]) ^ (sum_q + key_q[sum_q[1:0]]));
        sum_d   = sum_q + XTEA_DELTA;
        phase_d = 1'b1;
      end else begin
        w_d[1]  = w_q[1] + (mix(w_q[0]) ^ (sum_q + key_q[sum_q[12:11]]));
        phase_d = 1'b0;
        if (cnt_q == CntLast) begin
          cnt_d = '0;
          sum_d = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
    if (ctl_i.step) begin
      if (ctl_i.ld_key) begin
        key_d = SEED_KEY;
      end
      if (ctl_i.kx) begin
        key_d[ctl_i.kidx] = key_q[ctl_i.kidx] ^ kx_val;
      end
      if (ctl_i.clr) begin
        w_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= '0;
      key_q   <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      w_q     <= w_d;
      key_q   <= key_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

  assign last_o = ctl_i.enc && phase_q && (cnt_q == CntLast);
  assign mix_o  = w_q[0] ^ w_q[1];

endmodule

// ===== sv/xtea_prng.sv =====
// xtea_prng: random generator built on XTEA encryption of two state words.
// Usage: one input transaction carries an operation code and eight seed bytes;
// exactly one output transaction carries random_value for it.
//   Operation 0 encrypts the words and returns 15 bits of their XOR.
//   Operations 1 and 2 return bits 16:15 or bit 17 of that XOR, state unchanged.
//   Operation 3 reseeds from the fixed key and the two packed seed words;
//   its result is zero.
// Timing: a microcoded sequencer runs one XTEA half-round per cycle in xp_core.
// A draw runs one encryption, a peek none, and a seed loads the fixed key and
// runs encryptions interleaved with key updates. The result is registered:
// out_valid_o rises in the cycle after the final step completes, and the next
// transaction may be accepted then.
// One item is in work at a time; in_stall_o is high while it runs.
// Stall: the result waits in the output register while out_stall_i is high;
// a following item may run, and it holds at its final step until room frees up.
// Reset clears cipher and key words to zero and empties the output register.
// Uses xp_pkg and xp_core.
module xtea_prng #(
  parameter int unsigned ROUND_CYCLES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  alarm_hour_i,
  input  logic [7:0]  clock_hour_i,
  input  logic [7:0]  clock_minute_i,
  input  logic [7:0]  clock_second_i,
  input  logic [7:0]  alarm_minute_i,
  input  logic [7:0]  date_month_i,
  input  logic [7:0]  date_day_i,
  input  logic [7:0]  date_year_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [14:0] random_value_o
);
  import xp_pkg::*;

  state_e           state_q, state_d;
  logic [UPC_W-1:0] upc_q, upc_d;
  op_e              op_q, op_d;
  logic [31:0]      seed_a_q, seed_a_d, seed_b_q, seed_b_d;
  logic             out_valid_q, out_valid_d;
  logic [14:0]      rv_q, rv_d;
  uword_t           uw;
  core_ctl_t        ctl;
  logic             last;
  logic [31:0]      mix;
  logic             out_free;
  logic [14:0]      result;

  assign uw       = ucode(upc_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    ctl        = '0;
    ctl.enc    = (state_q == ST_RUN) && (uw.act == ACT_ENC);
    ctl.step   = (state_q == ST_RUN) && (uw.act == ACT_SET);
    ctl.ld_key = uw.ld_key;
    ctl.clr    = uw.clr;
    ctl.kx     = uw.kx;
    ctl.src    = uw.src;
    ctl.shr    = uw.shr;
    ctl.kidx   = uw.kidx;
  end

  xp_core #(
    .ROUND_CYCLES(ROUND_CYCLES)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .seed_a_i(seed_a_q),
    .seed_b_i(seed_b_q),
    .last_o  (last),
    .mix_o   (mix)
  );

  always_comb begin
    unique case (op_q)
      OP_DRAW:  result = mix[14:0];
      OP_PEEK2: result = {13'd0, mix[16:15]};
      OP_PEEK1: result = {14'd0, mix[17]};
      default:  result = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    upc_d       = upc_q;
    op_d        = op_q;
    seed_a_d    = seed_a_q;
    seed_b_d    = seed_b_q;
    out_valid_d = out_valid_q && out_stall_i;
    rv_d        = rv_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d  = ST_RUN;
          op_d     = op_e'(operation_i);
          upc_d    = entry(op_e'(operation_i));
          seed_a_d = {alarm_hour_i, clock_hour_i, clock_minute_i, clock_second_i};
          seed_b_d = {alarm_minute_i, date_month_i, date_day_i, date_year_i};
        end
      end
      ST_RUN: begin
        unique case (uw.act)
          ACT_ENC: begin
            if (last) begin
              upc_d = uw.nxt;
            end
          end
          ACT_SET: upc_d = uw.nxt;
          ACT_DONE: begin
            if (out_free) begin
              state_d     = ST_IDLE;
              upc_d       = uw.nxt;
              out_valid_d = 1'b1;
              rv_d        = result;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      upc_q       <= ADDR_DRAW;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    seed_a_q <= seed_a_d;
    seed_b_q <= seed_b_d;
    rv_q     <= rv_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign random_value_o = rv_q;

`ifndef SYNTHESIS
  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_RUN)
    else $error("accepted transaction did not start the sequencer");

  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_RUN) && state_q == ST_IDLE)
    else $error("result appeared without a finished program");

  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> upc_q <= ADDR_LAST)
    else $error("microcode address out of program");

  a_seed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN && uw.act == ACT_DONE && out_free && op_q == OP_SEED
    |=> random_value_o == '0)
    else $error("seed transaction returned nonzero value");
`endif

endmodule

// ===== dv/xtea_prng_chk.sv =====
// xtea_prng_chk: watches both channels of xtea_prng, predicts each random_value
// from its own XTEA state and key copy, and counts mismatches. Uses xp_pkg op codes.
`timescale 1ns / 100ps
module xtea_prng_chk #(
  parameter int unsigned ROUND_CYCLES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  alarm_hour_i,
  input  logic [7:0]  clock_hour_i,
  input  logic [7:0]  clock_minute_i,
  input  logic [7:0]  clock_second_i,
  input  logic [7:0]  alarm_minute_i,
  input  logic [7:0]  date_month_i,
  input  logic [7:0]  date_day_i,
  input  logic [7:0]  date_year_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [14:0] random_value_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);
  import xp_pkg::*;

  localparam logic [31:0]  GOLDEN = 32'h9E37_79B9;
  localparam logic [127:0] FIXED_KEY = {
    32'hB172_E6B0, 32'h2A77_FB57, 32'h993F_DDD1, 32'h2DE9_716E
  };

  logic [31:0] word0, word1;
  logic [31:0] key_w [4];
  logic [14:0] rand_q [$];
  logic [14:0] want;
  int unsigned errs;

  function automatic void encrypt_words();
    logic [31:0] a, b, s;
    a = word0;
    b = word1;
    s = '0;
    for (int n = 0; n < ROUND_CYCLES; n++) begin
      a = a + ((((b << 4) ^ (b >> 5)) + b) ^ (s + key_w[s[1:0]]));
      s = s + GOLDEN;
      b = b + ((((a << 4) ^ (a >> 5)) + a) ^ (s + key_w[s[12:11]]));
    end
    word0 = a;
    word1 = b;
  endfunction

  function automatic void reseed(input logic [31:0] wa, input logic [31:0] wb);
    for (int i = 0; i < 4; i++) key_w[i] = FIXED_KEY[32*i +: 32];
    word0 = '0;
    word1 = '0;
    encrypt_words();
    key_w[0] ^= word1 << 1;
    encrypt_words();
    key_w[1] ^= wa << 1;
    encrypt_words();
    key_w[2] ^= wa >> 1;
    encrypt_words();
    key_w[3] ^= word1 >> 1;
    encrypt_words();
    key_w[0] ^= wb << 1;
    encrypt_words();
    key_w[1] ^= word0 << 1;
    encrypt_words();
    key_w[2] ^= word0 >> 1;
    encrypt_words();
    key_w[3] ^= wb >> 1;
    word0 = '0;
    word1 = '0;
    encrypt_words();
  endfunction

  function automatic logic [14:0] next_random(input op_e op, input logic [31:0] wa,
                                              input logic [31:0] wb);
    logic [31:0] x;
    logic [14:0] r;
    r = '0;
    x = word0 ^ word1;
    case (op)
      OP_DRAW: begin
        encrypt_words();
        x = word0 ^ word1;
        r = x[14:0];
      end
      OP_PEEK2: r = {13'd0, x[16:15]};
      OP_PEEK1: r = {14'd0, x[17]};
      default: begin
        reseed(wa, wb);
        r = '0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word0 = '0;
      word1 = '0;
      for (int i = 0; i < 4; i++) key_w[i] = '0;
      rand_q.delete();
      errs = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        rand_q.push_back(next_random(op_e'(operation_i),
          {alarm_hour_i, clock_hour_i, clock_minute_i, clock_second_i},
          {alarm_minute_i, date_month_i, date_day_i, date_year_i}));
      end
      if (out_valid_i && !out_stall_i) begin
        if (rand_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected transaction: random_value=%h", random_value_i);
        end else begin
          want = rand_q.pop_front();
          if (want !== random_value_i) begin
            errs++;
            if (errs <= 10) begin
              $display("random_value mismatch: expected %h actual %h", want, random_value_i);
            end
          end
        end
      end
      err_cnt_o <= errs;
      pending_o <= rand_q.size();
    end
  end

endmodule

// ===== dv/xtea_prng_tb.sv =====
// xtea_prng_tb: drives directed and random operations into xtea_prng under
// varying sender/receiver idling; xtea_prng_chk predicts and compares. Uses xp_pkg.
`timescale 1ns / 100ps
module xtea_prng_tb;
  import xp_pkg::*;

  localparam int unsigned ROUND_CYCLES = 32;
  localparam int unsigned QUIET_LIMIT  = 8000;
  localparam int unsigned RAND_ITEMS   = 1550;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i    = OP_DRAW;
  logic [7:0]  alarm_hour_i   = '0;
  logic [7:0]  clock_hour_i   = '0;
  logic [7:0]  clock_minute_i = '0;
  logic [7:0]  clock_second_i = '0;
  logic [7:0]  alarm_minute_i = '0;
  logic [7:0]  date_month_i   = '0;
  logic [7:0]  date_day_i     = '0;
  logic [7:0]  date_year_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [14:0] random_value_o;

  int unsigned err_cnt, pending;
  int unsigned in_idle_pct  = 13;
  int unsigned out_idle_pct = 84;
  int unsigned quiet_cnt    = 0;

  xtea_prng #(.ROUND_CYCLES(ROUND_CYCLES)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i,
    .alarm_hour_i, .clock_hour_i, .clock_minute_i, .clock_second_i,
    .alarm_minute_i, .date_month_i, .date_day_i, .date_year_i,
    .out_valid_o, .out_stall_i, .random_value_o
  );

  xtea_prng_chk #(.ROUND_CYCLES(ROUND_CYCLES)) chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .operation_i,
    .alarm_hour_i, .clock_hour_i, .clock_minute_i, .clock_second_i,
    .alarm_minute_i, .date_month_i, .date_day_i, .date_year_i,
    .out_valid_i(out_valid_o), .out_stall_i, .random_value_i(random_value_o),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < out_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
    if (quiet_cnt >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // seeds: {alarm_hour, clock_hour, clock_minute, clock_second,
  //         alarm_minute, date_month, date_day, date_year}
  task automatic send_op(input op_e op, input logic [63:0] seeds);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    {alarm_hour_i, clock_hour_i, clock_minute_i, clock_second_i,
     alarm_minute_i, date_month_i, date_day_i, date_year_i} <= seeds;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    op_e         op;
    logic [63:0] seeds;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) op = OP_DRAW;
    else if (pick < 78) op = OP_PEEK2;
    else if (pick < 91) op = OP_PEEK1;
    else op = OP_SEED;
    case ($urandom_range(0, 9))
      0:       seeds = '0;
      1:       seeds = '1;
      default: seeds = {$urandom, $urandom};
    endcase
    send_op(op, seeds);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // peeks and draws on the all-zero reset state, then reseeds followed by draws and peeks
    send_op(OP_PEEK2, '0);
    send_op(OP_PEEK1, '1);
    send_op(OP_DRAW, '0);
    send_op(OP_PEEK2, '0);
    send_op(OP_PEEK1, '0);
    send_op(OP_DRAW, '1);
    send_op(OP_SEED, '0);
    send_op(OP_DRAW, '0);
    send_op(OP_PEEK2, '0);
    send_op(OP_PEEK1, '0);
    send_op(OP_SEED, '1);
    send_op(OP_DRAW, '0);
    send_op(OP_DRAW, '0);
    send_op(OP_SEED, 64'hAA55_AA55_55AA_55AA);
    send_op(OP_DRAW, '0);
    send_op(OP_SEED, 64'h55AA_55AA_AA55_AA55);
    send_op(OP_DRAW, '0);
    send_op(OP_PEEK1, '0);
    send_op(OP_SEED, {$urandom, $urandom});
    send_op(OP_DRAW, '0);
    send_op(OP_PEEK2, '0);

    for (int i = 0; i < RAND_ITEMS / 3; i++) send_random();
    in_idle_pct  <= 84;
    out_idle_pct <= 13;
    for (int i = 0; i < RAND_ITEMS / 3; i++) send_random();
    in_idle_pct  <= 0;
    out_idle_pct <= 0;
    for (int i = 0; i < RAND_ITEMS - 2 * (RAND_ITEMS / 3); i++) send_random();

    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (2 * ROUND_CYCLES + 8) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
